>>> sv/tbsq_pkg.sv
// ----------------------------------------------------------------------------
// tbsq_pkg
// shared constants and types of the binary search quantizer
// ----------------------------------------------------------------------------
package tbsq_pkg;

  // default sizes
  localparam int MAX_BITS_DEF    = 8;
  localparam int VALUE_WIDTH_DEF = 16;

  // fixed field widths of the channels
  localparam int ADDR_IN_W = 9;
  localparam int BITS_W    = 4;
  localparam int INDEX_W   = 8;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUANT = 1'b1
  } tbsq_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL
  } tbsq_state_t;

endpackage

>>> sv/tbsq_in_if.sv
// ----------------------------------------------------------------------------
// tbsq_in_if
// input channel: level writes and quantize requests
// ----------------------------------------------------------------------------
interface tbsq_in_if #(
  parameter int VALUE_WIDTH = tbsq_pkg::VALUE_WIDTH_DEF
);
  import tbsq_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [ADDR_IN_W-1:0]          table_address;
  logic signed [VALUE_WIDTH-1:0] table_value;
  logic signed [VALUE_WIDTH-1:0] sample;
  logic [BITS_W-1:0]             bits;

  modport source (
    output valid, command, table_address, table_value, sample, bits,
    input  ready
  );

  modport sink (
    input  valid, command, table_address, table_value, sample, bits,
    output ready
  );

endinterface

>>> sv/tbsq_out_if.sv
// ----------------------------------------------------------------------------
// tbsq_out_if
// result channel: chosen level index and level value
// ----------------------------------------------------------------------------
interface tbsq_out_if #(
  parameter int VALUE_WIDTH = tbsq_pkg::VALUE_WIDTH_DEF
);
  import tbsq_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [INDEX_W-1:0]            level_index;
  logic signed [VALUE_WIDTH-1:0] level_value;

  modport source (
    output valid, level_index, level_value,
    input  ready
  );

  modport sink (
    input  valid, level_index, level_value,
    output ready
  );

endinterface

>>> sv/tbsq_level_mem.sv
// ----------------------------------------------------------------------------
// tbsq_level_mem
// level store: one write port, two registered read ports
// ----------------------------------------------------------------------------
module tbsq_level_mem #(
  parameter int ADDR_W  = tbsq_pkg::MAX_BITS_DEF + 1,
  parameter int VALUE_W = tbsq_pkg::VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [VALUE_W-1:0] wr_data,
  input  logic [ADDR_W-1:0]  rd_lo_addr,
  input  logic [ADDR_W-1:0]  rd_hi_addr,
  output logic [VALUE_W-1:0] rd_lo_data_r,
  output logic [VALUE_W-1:0] rd_hi_data_r
);

  localparam int DEPTH = 1 << ADDR_W;

  logic [VALUE_W-1:0] level_store [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      level_store[wr_addr] <= wr_data;
    end
    rd_lo_data_r <= level_store[rd_lo_addr];
    rd_hi_data_r <= level_store[rd_hi_addr];
  end

endmodule

>>> sv/tbsq_search_ctrl.sv
// ----------------------------------------------------------------------------
// tbsq_search_ctrl
// handshake, binary search sequencer and result register
// ----------------------------------------------------------------------------
module tbsq_search_ctrl #(
  parameter int MAX_BITS    = tbsq_pkg::MAX_BITS_DEF,
  parameter int VALUE_WIDTH = tbsq_pkg::VALUE_WIDTH_DEF,
  parameter int ADDR_W      = MAX_BITS + 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  tbsq_in_if.sink                in_ch,
  tbsq_out_if.source             out_ch,
  output logic                   wr_en,
  output logic [ADDR_W-1:0]      wr_addr,
  output logic [VALUE_WIDTH-1:0] wr_data,
  output logic [ADDR_W-1:0]      rd_lo_addr,
  output logic [ADDR_W-1:0]      rd_hi_addr,
  input  logic [VALUE_WIDTH-1:0] rd_lo_data_r,
  input  logic [VALUE_WIDTH-1:0] rd_hi_data_r
);
  import tbsq_pkg::*;

  tbsq_state_t state_r, state_nxt;

  logic [BITS_W-1:0]      steps_r, steps_nxt;
  logic [MAX_BITS-1:0]    offset_r, offset_nxt;
  logic [MAX_BITS-1:0]    weight_r, weight_nxt;
  logic [ADDR_W-1:0]      hi_addr_r, hi_addr_nxt;
  logic [ADDR_W-1:0]      base_r, base_nxt;
  logic [VALUE_WIDTH-1:0] sample_r, sample_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [INDEX_W-1:0]     out_index_r, out_index_nxt;
  logic [VALUE_WIDTH-1:0] out_value_r, out_value_nxt;

  logic in_acc, acc_write, acc_quant, slot_free, go_up, last_step;
  logic [BITS_W-1:0] k_sat;
  logic [MAX_BITS-1:0] offset_init;
  logic [ADDR_W-1:0] base_init, hi_up, hi_dn, w_ext;
  logic signed [VALUE_WIDTH:0] lvl_sum, sample_x2;
  logic [MAX_BITS-1:0] idx_pick;
  logic [ADDR_W+ADDR_IN_W-1:0] wr_addr_wide;
  logic [INDEX_W+MAX_BITS-1:0] idx_wide;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign acc_write   = in_acc && (in_ch.command == CMD_WRITE);
  assign acc_quant   = in_acc && (in_ch.command == CMD_QUANT);
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign last_step   = (steps_r == '0);

  // store writes go straight through on the accept edge
  assign wr_addr_wide = {{ADDR_W{1'b0}}, in_ch.table_address};
  assign wr_en        = acc_write;
  assign wr_addr      = wr_addr_wide[ADDR_W-1:0];
  assign wr_data      = in_ch.table_value;

  // bit count saturates into 1..MAX_BITS
  always_comb begin
    if (in_ch.bits == '0) begin
      k_sat = BITS_W'(1);
    end else if (in_ch.bits > BITS_W'(MAX_BITS)) begin
      k_sat = BITS_W'(MAX_BITS);
    end else begin
      k_sat = in_ch.bits;
    end
  end

  assign offset_init = MAX_BITS'(1) << (k_sat - BITS_W'(1));
  assign base_init   = (ADDR_W'(1) << k_sat) - ADDR_W'(2);

  // threshold test 2*sample > lo + hi, exact in one extra bit
  assign lvl_sum   = $signed({rd_lo_data_r[VALUE_WIDTH-1], rd_lo_data_r})
                   + $signed({rd_hi_data_r[VALUE_WIDTH-1], rd_hi_data_r});
  assign sample_x2 = $signed({sample_r, 1'b0});
  assign go_up     = sample_x2 > lvl_sum;

  // both candidate addresses are prepared off registers
  assign w_ext = ADDR_W'(weight_r);
  assign hi_up = hi_addr_r + w_ext;
  assign hi_dn = hi_addr_r - w_ext;

  assign idx_pick = go_up ? offset_r : (offset_r - MAX_BITS'(1));
  assign idx_wide = {{INDEX_W{1'b0}}, idx_pick};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_quant) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (last_step && slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    steps_nxt     = steps_r;
    offset_nxt    = offset_r;
    weight_nxt    = weight_r;
    hi_addr_nxt   = hi_addr_r;
    base_nxt      = base_r;
    sample_nxt    = sample_r;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    rd_hi_addr    = hi_addr_r;
    case (state_r)
      ST_IDLE: begin
        if (acc_quant) begin
          steps_nxt   = k_sat - BITS_W'(1);
          offset_nxt  = offset_init;
          weight_nxt  = offset_init >> 1;
          base_nxt    = base_init;
          hi_addr_nxt = base_init + ADDR_W'(offset_init);
          sample_nxt  = in_ch.sample;
        end
      end
      ST_READ: begin
        rd_hi_addr = hi_addr_r;
      end
      ST_EVAL: begin
        if (!last_step) begin
          steps_nxt   = steps_r - BITS_W'(1);
          weight_nxt  = weight_r >> 1;
          offset_nxt  = go_up ? (offset_r + weight_r) : (offset_r - weight_r);
          hi_addr_nxt = go_up ? hi_up : hi_dn;
          rd_hi_addr  = hi_addr_nxt;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_index_nxt = idx_wide[INDEX_W-1:0];
          out_value_nxt = go_up ? rd_hi_data_r : rd_lo_data_r;
        end
      end
      default: begin
        rd_hi_addr = hi_addr_r;
      end
    endcase
    rd_lo_addr = rd_hi_addr - ADDR_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steps_r     <= steps_nxt;
    offset_r    <= offset_nxt;
    weight_r    <= weight_nxt;
    hi_addr_r   <= hi_addr_nxt;
    base_r      <= base_nxt;
    sample_r    <= sample_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.level_index = out_index_r;
  assign out_ch.level_value = out_value_r;

  // search pointer never falls to the bottom of the segment
  a_offset_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> (offset_r != '0))
    else $error("search offset reached zero");

  // absolute address stays in step with the segment offset
  a_addr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> (hi_addr_r == base_r + ADDR_W'(offset_r)))
    else $error("store address lost track of offset");

  // step weight is a single bit or exhausted
  a_weight_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EVAL) |-> $onehot0(weight_r))
    else $error("step weight is not a power of two");

  // a level write makes no result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_write && !out_valid_r) |=> !out_valid_r)
    else $error("write produced a result");

  // a quantize request starts the store read at once
  a_quant_start: assert property (@(posedge clk) disable iff (!rst_n)
    acc_quant |=> (state_r == ST_READ))
    else $error("quantize request did not start a search");

endmodule

>>> sv/table_binary_search_quantizer.sv
// ----------------------------------------------------------------------------
// table_binary_search_quantizer
// nonlinear scalar quantizer, binary search over a stored level table
// ----------------------------------------------------------------------------
// operation: an accepted quantize beat first reads the level store, then makes one compare per
//   search step; the last compare also picks the result, which is held until the result slot is free
// throughput: no new quantize beat is taken until its search is done; one write beat per cycle
//   while no search runs; each search step makes a single compare on a registered store read
// reset: synchronous active low, clears the sequencer and result valid;
//   the level store is not cleared and holds garbage until written
module table_binary_search_quantizer #(
  parameter int MAX_BITS    = tbsq_pkg::MAX_BITS_DEF,
  parameter int VALUE_WIDTH = tbsq_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  tbsq_in_if.sink    in_ch,
  tbsq_out_if.source out_ch
);

  // segment k lives at entries 2^k-2 .. 2^(k+1)-3, so the store is 2^(MAX_BITS+1) deep
  localparam int ADDR_W = MAX_BITS + 1;

  // store write port, driven on an accepted write beat
  logic                   wr_en;
  logic [ADDR_W-1:0]      wr_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  // two adjacent levels read per search step
  logic [ADDR_W-1:0]      rd_lo_addr;
  logic [ADDR_W-1:0]      rd_hi_addr;
  logic [VALUE_WIDTH-1:0] rd_lo_data_r;
  logic [VALUE_WIDTH-1:0] rd_hi_data_r;

  // sequencer: accepts beats, walks the search, holds the result register
  tbsq_search_ctrl #(
    .MAX_BITS    (MAX_BITS),
    .VALUE_WIDTH (VALUE_WIDTH),
    .ADDR_W      (ADDR_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_lo_addr   (rd_lo_addr),
    .rd_hi_addr   (rd_hi_addr),
    .rd_lo_data_r (rd_lo_data_r),
    .rd_hi_data_r (rd_hi_data_r)
  );

  // level store with registered read data
  tbsq_level_mem #(
    .ADDR_W  (ADDR_W),
    .VALUE_W (VALUE_WIDTH)
  ) u_mem (
    .clk          (clk),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .rd_lo_addr   (rd_lo_addr),
    .rd_hi_addr   (rd_hi_addr),
    .rd_lo_data_r (rd_lo_data_r),
    .rd_hi_data_r (rd_hi_data_r)
  );

endmodule
